// ----- rtl/hmms_pkg.sv -----
package hmms_pkg;

  localparam int PixW     = 8;
  localparam int NumCh    = 3;
  localparam int NumW     = 2 * PixW;
  localparam int DivSteps = PixW;
  localparam int CntW     = $clog2(DivSteps);
  localparam int LumW     = PixW + 5;

  localparam logic [PixW-1:0] PixMax = {PixW{1'b1}};

  localparam logic ReqMeasure = 1'b0;
  localparam logic ReqMap     = 1'b1;

  typedef logic [NumCh-1:0][PixW-1:0] pix_vec_t;

  typedef struct packed {
    pix_vec_t lo;
    pix_vec_t hi;
  } stats_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [PixW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PixW-1:0] quot;
  } div_rsp_t;

  // Luminance weights sum to 32, so the result always fits one pixel.
  function automatic logic [PixW-1:0] lum_f(input logic [PixW-1:0] r,
                                            input logic [PixW-1:0] g,
                                            input logic [PixW-1:0] b);
    logic [LumW-1:0] sum;
    sum = {5'b0, r} * LumW'(11) + {5'b0, g} * LumW'(16) + {5'b0, b} * LumW'(5);
    return sum[LumW-1:5];
  endfunction

endpackage

// ----- rtl/histogram_min_max_stretch.sv -----
// Min-max contrast stretch for RGB pixels, run as two passes over a frame.
// Input channel (in_valid/in_ready): a measure beat (req_type 0) folds the
// pixel into the per-channel minimum and maximum; frame_start on it clears
// them first. A measure beat gives no result and leaves the block idle.
// A map beat (req_type 1) gives one result beat on the out_ channel with the
// stretched channels and a flat bit per channel where max is not above min.
// gray_mode, written through cfg_wr_en/cfg_wr_data, selects luminance mode.
// A map beat occupies the block through a load state, the radix-2
// dividers (one per channel, one quotient bit per cycle) and a finishing
// state that hands the result to the output register. in_ready is low
// for that whole time, so no new beat is taken until the map beat is done.
// The output register frees the datapath once loaded; if the receiver
// stalls with a result still held, the next map result waits in the
// finishing state and in_ready stays low until the held beat is taken.
// Reset (rst_n low, synchronous) sets minimum to 255 and maximum to 0 for
// all channels, clears gray_mode and empties the output register.
module histogram_min_max_stretch import hmms_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_req_type,
  input  logic            in_frame_start,
  input  logic [PixW-1:0] in_red,
  input  logic [PixW-1:0] in_green,
  input  logic [PixW-1:0] in_blue,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PixW-1:0] out_red,
  output logic [PixW-1:0] out_green,
  output logic [PixW-1:0] out_blue,
  output logic [NumCh-1:0] out_flat_mask,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state_r;
  logic             gray_mode_r;
  logic             in_acc;
  logic [PixW-1:0]  lum;
  pix_vec_t         in_vals;
  pix_vec_t         val_r;
  stats_t           stats;
  logic [NumCh-1:0] flat_r, low_r, sat_r;
  logic [NumCh-1:0] div_done;
  pix_vec_t         res;
  logic             out_valid_r;
  pix_vec_t         out_pix_r;
  logic [NumCh-1:0] out_flat_r;
  logic             out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign lum      = lum_f(in_red, in_green, in_blue);
  assign in_vals  = gray_mode_r ? {NumCh{lum}} : {in_blue, in_green, in_red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      gray_mode_r <= cfg_wr_data;
    end
  end

  hmms_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .meas_en (in_acc && (in_req_type == ReqMeasure)),
    .clear   (in_frame_start),
    .vals    (in_vals),
    .stats   (stats)
  );

  for (genvar i = 0; i < NumCh; i++) begin : g_lane
    logic [PixW-1:0] lo, hi, v, span, rise;
    div_req_t        dreq;
    div_rsp_t        drsp;

    // In gray mode every lane works on channel 0 statistics.
    assign lo   = gray_mode_r ? stats.lo[0] : stats.lo[i];
    assign hi   = gray_mode_r ? stats.hi[0] : stats.hi[i];
    assign v    = val_r[i];
    assign span = hi - lo;
    assign rise = v - lo;

    assign dreq.start = (state_r == S_LOAD);
    assign dreq.num   = {rise, {PixW{1'b0}}} - {{PixW{1'b0}}, rise};
    assign dreq.den   = span;

    hmms_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (dreq),
      .rsp   (drsp)
    );

    assign div_done[i] = drsp.done;

    always_ff @(posedge clk) begin
      if (state_r == S_LOAD) begin
        flat_r[i] <= (hi <= lo);
        low_r[i]  <= (v <= lo);
        sat_r[i]  <= (v >= hi);
      end
    end

    // A value at or above max would divide to 255 or more, so it saturates here.
    assign res[i] = flat_r[i] ? v :
                    low_r[i]  ? '0 :
                    sat_r[i]  ? PixMax : drsp.quot;
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_req_type == ReqMap)) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done[0]) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r <= in_vals;
    end
    if (out_load) begin
      out_pix_r  <= res;
      out_flat_r <= flat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_pix_r[0];
  assign out_green     = out_pix_r[1];
  assign out_blue      = out_pix_r[2];
  assign out_flat_mask = out_flat_r;

  a_map_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_req_type == ReqMap)) |=> (state_r == S_LOAD))
    else $error("map beat did not start the divide sequence");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_done == '0 || div_done == '1))
    else $error("divider lanes finished in different cycles");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the finishing state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> !(state_r == S_IDLE && $past(div_done[0]) == 1'b0))
    else $error("sequencer left the divide state early");

endmodule

// ----- rtl/hmms_div.sv -----
module hmms_div import hmms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [PixW-1:0] rem_r, rem_nxt;
  logic [PixW-1:0] quo_r, quo_nxt;
  logic [PixW-1:0] den_r;
  logic [CntW-1:0] cnt_r;
  logic            run_r;
  logic [PixW:0]   trial;
  logic [PixW:0]   diff;
  logic            ge;

  // Low numerator bits shift out of quo_r while quotient bits shift in.
  assign trial   = {rem_r, quo_r[PixW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[PixW-1:0] : trial[PixW-1:0];
  assign quo_nxt = {quo_r[PixW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CntW'(DivSteps - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[NumW-1:PixW];
      quo_r <= req.num[PixW-1:0];
      den_r <= req.den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = run_r && (cnt_r == CntW'(DivSteps - 1));
  assign rsp.quot = quo_r;

endmodule

// ----- rtl/hmms_stats.sv -----
module hmms_stats import hmms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     meas_en,
  input  logic     clear,
  input  pix_vec_t vals,
  output stats_t   stats
);

  pix_vec_t lo_r, lo_nxt;
  pix_vec_t hi_r, hi_nxt;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      logic [PixW-1:0] lo_base;
      logic [PixW-1:0] hi_base;
      lo_base   = clear ? PixMax : lo_r[i];
      hi_base   = clear ? '0 : hi_r[i];
      lo_nxt[i] = (vals[i] < lo_base) ? vals[i] : lo_base;
      hi_nxt[i] = (vals[i] > hi_base) ? vals[i] : hi_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= {NumCh{PixMax}};
      hi_r <= '0;
    end else if (meas_en) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign stats.lo = lo_r;
  assign stats.hi = hi_r;

endmodule

// ----- dv/tb_histogram_min_max_stretch.sv -----
`timescale 1ns / 1ps

module tb_histogram_min_max_stretch;
  import hmms_pkg::*;

  localparam int RandItems = 1500;
  // Leaves a map beat time to finish in the block, with some margin.
  localparam int SettleCycles = 14;

  typedef struct packed {
    logic [PixW-1:0]  red;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  blue;
    logic [NumCh-1:0] flat;
  } stretched_pix_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic            in_req_type;
  logic            in_frame_start;
  logic [PixW-1:0] in_red;
  logic [PixW-1:0] in_green;
  logic [PixW-1:0] in_blue;
  logic            out_valid;
  logic            out_ready;
  logic [PixW-1:0] out_red;
  logic [PixW-1:0] out_green;
  logic [PixW-1:0] out_blue;
  logic [NumCh-1:0] out_flat_mask;
  logic            cfg_wr_en;
  logic            cfg_wr_data;

  // Shadow of the block's statistics and mode register.
  logic [PixW-1:0] stat_lo [NumCh];
  logic [PixW-1:0] stat_hi [NumCh];
  logic            gray_sel;

  stretched_pix_t expected_pixels [$];
  int             mismatch_count;
  int             sent_count;
  int             rx_hold;
  bit             tx_gaps_on;
  bit             rx_gaps_on;

  histogram_min_max_stretch i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_frame_start(in_frame_start),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_flat_mask (out_flat_mask),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PixW-1:0] luma_of(logic [PixW-1:0] r, logic [PixW-1:0] g,
                                              logic [PixW-1:0] b);
    int s;
    s = 11 * int'(r) + 16 * int'(g) + 5 * int'(b);
    return PixW'(s >> 5);
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i < NumCh; i++) begin
      stat_lo[i] = PixMax;
      stat_hi[i] = '0;
    end
  endfunction

  function automatic void fold_value(int ch, logic [PixW-1:0] v);
    if (v < stat_lo[ch]) stat_lo[ch] = v;
    if (v > stat_hi[ch]) stat_hi[ch] = v;
  endfunction

  function automatic logic [PixW-1:0] stretch_value(int ch, logic [PixW-1:0] v,
                                                    output logic flat);
    int lo, hi, q;
    lo = int'(stat_lo[ch]);
    hi = int'(stat_hi[ch]);
    if (hi <= lo) begin
      flat = 1'b1;
      return v;
    end
    flat = 1'b0;
    if (int'(v) <= lo) return '0;
    q = (255 * (int'(v) - lo)) / (hi - lo);
    if (q > 255) q = 255;
    return PixW'(q);
  endfunction

  // Applies one accepted beat to the shadow state and queues its result, if any.
  function automatic void predict_pixel(logic req, logic fs, logic [PixW-1:0] r,
                                        logic [PixW-1:0] g, logic [PixW-1:0] b);
    stretched_pix_t res;
    logic [PixW-1:0] l;
    logic f0, f1, f2;
    l = luma_of(r, g, b);
    if (req == ReqMeasure) begin
      if (fs) clear_stats();
      if (gray_sel) begin
        for (int i = 0; i < NumCh; i++) fold_value(i, l);
      end else begin
        fold_value(0, r);
        fold_value(1, g);
        fold_value(2, b);
      end
    end else begin
      if (gray_sel) begin
        res.red   = stretch_value(0, l, f0);
        res.green = res.red;
        res.blue  = res.red;
        res.flat  = {f0, f0, f0};
      end else begin
        res.red   = stretch_value(0, r, f0);
        res.green = stretch_value(1, g, f1);
        res.blue  = stretch_value(2, b, f2);
        res.flat  = {f2, f1, f0};
      end
      expected_pixels.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_pixel(logic req, logic fs, logic [PixW-1:0] r, logic [PixW-1:0] g,
                            logic [PixW-1:0] b);
    int gap;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_frame_start <= fs;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    do @(posedge clk); while (!in_ready);
    predict_pixel(req, fs, r, g, b);
    sent_count++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering beats and waits until every queued result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_gray(logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gray_sel = v;
  endtask

  task automatic test_empty_stats();
    // Nothing measured since reset: every channel is flat and passes through.
    send_pixel(ReqMap, 1'b0, 8'd0, 8'd255, 8'd17);
    send_pixel(ReqMap, 1'b1, 8'd255, 8'd0, 8'd128);
    wait_idle();
  endtask

  task automatic test_rgb_stretch();
    send_pixel(ReqMeasure, 1'b1, 8'd40, 8'd50, 8'd60);
    send_pixel(ReqMeasure, 1'b0, 8'd200, 8'd180, 8'd250);
    send_pixel(ReqMap, 1'b0, 8'd40, 8'd50, 8'd60);
    send_pixel(ReqMap, 1'b0, 8'd200, 8'd180, 8'd250);
    send_pixel(ReqMap, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(ReqMap, 1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(ReqMap, 1'b0, 8'd120, 8'd115, 8'd155);
    wait_idle();
  endtask

  task automatic test_flat_span();
    send_pixel(ReqMeasure, 1'b1, 8'd77, 8'd77, 8'd77);
    send_pixel(ReqMap, 1'b0, 8'd77, 8'd0, 8'd255);
    wait_idle();
  endtask

  task automatic test_gray_mode();
    write_gray(1'b1);
    send_pixel(ReqMeasure, 1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(ReqMeasure, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(ReqMap, 1'b0, 8'd128, 8'd64, 8'd200);
    send_pixel(ReqMeasure, 1'b1, 8'd100, 8'd100, 8'd100);
    send_pixel(ReqMap, 1'b0, 8'd3, 8'd250, 8'd90);
    send_pixel(ReqMeasure, 1'b0, 8'd180, 8'd20, 8'd60);
    wait_idle();
    // Statistics gathered in gray mode, then used per channel.
    write_gray(1'b0);
    send_pixel(ReqMap, 1'b0, 8'd90, 8'd130, 8'd255);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold = 400;
    send_pixel(ReqMeasure, 1'b1, 8'd10, 8'd20, 8'd30);
    send_pixel(ReqMeasure, 1'b0, 8'd240, 8'd230, 8'd220);
    repeat (40) send_pixel(ReqMap, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  function automatic logic [PixW-1:0] pick_value(int style, logic [PixW-1:0] base);
    int v;
    case (style)
      0: v = $urandom_range(0, 255);
      1: v = int'(base) + $urandom_range(0, 15) - 8;
      default: v = int'(base);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PixW'(v);
  endfunction

  task automatic test_random_frames();
    int start, style, map_style, n_meas, n_map;
    logic [PixW-1:0] br, bg, bb;
    start = sent_count;
    while (sent_count - start < RandItems) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        wait_idle();
        write_gray(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 6) == 0) begin
        // Unstructured beats: any mix of measure, map and frame starts.
        repeat ($urandom_range(1, 10))
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end else begin
        style  = $urandom_range(0, 2);
        br     = PixW'($urandom_range(0, 255));
        bg     = PixW'($urandom_range(0, 255));
        bb     = PixW'($urandom_range(0, 255));
        n_meas = $urandom_range(0, 15);
        n_map  = $urandom_range(1, 20);
        send_pixel(ReqMeasure, 1'b1, pick_value(style, br), pick_value(style, bg),
                   pick_value(style, bb));
        repeat (n_meas)
          send_pixel(ReqMeasure, 1'b0, pick_value(style, br), pick_value(style, bg),
                     pick_value(style, bb));
        if ($urandom_range(0, 9) == 0) begin
          wait_idle();
          write_gray(~gray_sel);
        end
        repeat (n_map) begin
          map_style = $urandom_range(0, 1) ? 0 : style;
          send_pixel(ReqMap, 1'($urandom_range(0, 1)), pick_value(map_style, br),
                     pick_value(map_style, bg), pick_value(map_style, bb));
        end
      end
    end
    wait_idle();
  endtask

  // Receiver: random stalls, plus a long hold-off when rx_hold is loaded.
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rx_gaps_on) stall = pick_gap();
      end
    end
  end

  // Every result beat is checked against the oldest queued expectation.
  initial begin
    stretched_pix_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red)
            report_mismatch($sformatf("out_red %0d, expected %0d", out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("out_green %0d, expected %0d", out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("out_blue %0d, expected %0d", out_blue, want.blue));
          if (out_flat_mask !== want.flat)
            report_mismatch($sformatf("out_flat_mask %b, expected %b", out_flat_mask,
                                      want.flat));
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    sent_count     = 0;
    rx_hold        = 0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    gray_sel       = 1'b0;
    clear_stats();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= ReqMeasure;
    in_frame_start <= 1'b0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stats();
    test_rgb_stretch();
    test_flat_span();
    test_gray_mode();
    test_backpressure();
    test_random_frames();

    wait_idle();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
